// ----- design/m3inv_pkg.sv -----
package m3inv_pkg;

    localparam int ELEM_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int OUT_FRAC = 16;
    localparam int COF_W   = 2 * ELEM_W + 1;           // cofactor, exact
    localparam int DET_W   = 3 * ELEM_W + 1;           // determinant, exact
    localparam int SH      = FRAC_W + OUT_FRAC;        // quotient scale
    localparam int NUM_W   = COF_W + SH;               // scaled numerator magnitude
    localparam int QUO_W   = 34;                       // quotient kept, saturating
    localparam int IN_W    = 9 * ELEM_W;
    localparam int OUT_W   = 9 * 32 + DET_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int NDIV    = NUM_W;                    // one quotient bit per stage

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [DET_W-1:0]         mag_t;

    // restoring division lane state, one per inverse element
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DET_W:0]   rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             zero;
    } lane_t;

endpackage

// ----- design/m3inv_front.sv -----
module m3inv_front
    import m3inv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [IN_W-1:0]    in_data,
    output logic               out_valid,
    output cof_t               cof_out [9],
    output det_t               det_out
);
    elem_t a [3][3];
    logic signed [2*ELEM_W-1:0] p1_reg [9], p2_reg [9];
    elem_t  r0_reg [3];
    logic   v1_reg, v2_reg;
    cof_t   cof_reg [9];
    logic signed [COF_W+ELEM_W-1:0] t_reg [3];
    det_t   det_reg;
    logic   v3_reg;

    always_comb begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r][c] = elem_t'(in_data[(r*3+c)*ELEM_W +: ELEM_W]);
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) begin
                    p1_reg[r*3+c] <= a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3];
                    p2_reg[r*3+c] <= a[(r+2)%3][(c+1)%3] * a[(r+1)%3][(c+2)%3];
                end
            for (int c = 0; c < 3; c++)
                r0_reg[c] <= a[0][c];
        end
    end

    // stage 2: cofactors; stage 3: first-row terms; stage 4: sum
    cof_t cof2_reg [9];
    elem_t r0b_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++)
                cof2_reg[i] <= cof_t'(p1_reg[i]) - cof_t'(p2_reg[i]);
            r0b_reg <= r0_reg;
            for (int c = 0; c < 3; c++)
                t_reg[c] <= r0b_reg[c] * cof2_reg[c];
            cof_reg <= cof2_reg;
            det_reg <= det_t'(t_reg[0]) + det_t'(t_reg[1]) + det_t'(t_reg[2]);
        end
    end

    cof_t cof3_reg [9];
    logic v2b_reg;
    always_ff @(posedge aclk) begin
        if (en) cof3_reg <= cof_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v2b_reg <= 1'b0; v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v2b_reg <= v2_reg; v3_reg <= v2b_reg;
        end
    end

    assign cof_out   = cof3_reg;
    assign det_out   = det_reg;
    assign out_valid = v3_reg;
endmodule

// ----- design/m3inv_div.sv -----
module m3inv_div
    import m3inv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  cof_t        cof_in [9],
    input  det_t        det_in,
    output logic        out_valid,
    output logic [31:0] inv_out [9],
    output det_t        det_out
);
    lane_t lane_reg [NDIV+1][9];
    mag_t  d_reg    [NDIV+1];
    det_t  det_reg  [NDIV+1];
    logic  v_reg    [NDIV+1];
    lane_t lane_next [NDIV+1][9];
    logic [COF_W-1:0] nmag [9];
    logic [DET_W:0]   trial [NDIV][9];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            nmag[i] = cof_in[i][COF_W-1] ? COF_W'(-cof_in[i]) : COF_W'(cof_in[i]);
            lane_next[0][i].num  = {nmag[i], {SH{1'b0}}};
            lane_next[0][i].rem  = '0;
            lane_next[0][i].quo  = '0;
            lane_next[0][i].neg  = cof_in[i][COF_W-1] ^ det_in[DET_W-1];
            lane_next[0][i].zero = (cof_in[i] == '0) || (det_in == '0);
        end
        for (int s = 0; s < NDIV; s++)
            for (int i = 0; i < 9; i++) begin
                lane_next[s+1][i] = lane_reg[s][i];
                trial[s][i] = {lane_reg[s][i].rem[DET_W-1:0],
                               lane_reg[s][i].num[NUM_W-1]};
                lane_next[s+1][i].num = {lane_reg[s][i].num[NUM_W-2:0], 1'b0};
                if (trial[s][i] >= {1'b0, d_reg[s]}) begin
                    lane_next[s+1][i].rem = trial[s][i] - {1'b0, d_reg[s]};
                    lane_next[s+1][i].quo = lane_reg[s][i].quo[QUO_W-1]
                        ? lane_reg[s][i].quo : {lane_reg[s][i].quo[QUO_W-2:0], 1'b1};
                end else begin
                    lane_next[s+1][i].rem = trial[s][i];
                    lane_next[s+1][i].quo = lane_reg[s][i].quo[QUO_W-1]
                        ? lane_reg[s][i].quo : {lane_reg[s][i].quo[QUO_W-2:0], 1'b0};
                end
            end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg[0] <= lane_next[0];
            d_reg[0]    <= det_in[DET_W-1] ? mag_t'(-det_in) : mag_t'(det_in);
            det_reg[0]  <= det_in;
            for (int s = 0; s < NDIV; s++) begin
                lane_reg[s+1] <= lane_next[s+1];
                d_reg[s+1]    <= d_reg[s];
                det_reg[s+1]  <= det_reg[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NDIV; s++) v_reg[s] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int s = 0; s < NDIV; s++) v_reg[s+1] <= v_reg[s];
        end
    end

    // sticky top bit marks overflow; zero lanes give 0, others saturate and sign
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            if (lane_reg[NDIV][i].zero)
                inv_out[i] = '0;
            else if (lane_reg[NDIV][i].neg)
                inv_out[i] = (lane_reg[NDIV][i].quo > QUO_W'(32'h8000_0000))
                    ? 32'h8000_0000 : 32'(-lane_reg[NDIV][i].quo);
            else
                inv_out[i] = (lane_reg[NDIV][i].quo > QUO_W'(32'h7FFF_FFFF))
                    ? 32'h7FFF_FFFF : lane_reg[NDIV][i].quo[31:0];
        end
    end

    assign det_out   = det_reg[NDIV];
    assign out_valid = v_reg[NDIV];
endmodule

// ----- design/matrix3_inverse.sv -----
// throughput: one matrix per cycle unless m_tready stalls a held result;
// 4 multiply/add stages, then one quotient bit per stage for 57 stages over nine
// parallel division lanes
// reset: aresetn synchronous active low clears all valid bits; data unreset
module matrix3_inverse
    import m3inv_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,   // a00..a22, 16 bits each, lowest first
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES_W-1:0] m_tdata,   // inv00..inv22, det_value(49)
    output logic                   m_tuser    // invertible
);
    logic en, fv, dv;
    cof_t cof [9];
    det_t det_f, det_d;
    logic [31:0] inv [9];
    logic [OUT_W-1:0] pack;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_user_reg;

    // whole pipeline advances when the result register is free or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    m3inv_front u_front (
        .aclk, .aresetn, .en, .in_valid(s_tvalid && en), .in_data(s_tdata),
        .out_valid(fv), .cof_out(cof), .det_out(det_f)
    );

    m3inv_div u_div (
        .aclk, .aresetn, .en, .in_valid(fv), .cof_in(cof), .det_in(det_f),
        .out_valid(dv), .inv_out(inv), .det_out(det_d)
    );

    // transpose: inv[r][c] = cof[c][r]
    always_comb begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                pack[(r*3+c)*32 +: 32] = inv[c*3+r];
        pack[OUT_W-1 -: DET_W] = det_d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= pack;
            out_user_reg <= (det_d != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BYTES_W'(out_data_reg);
    assign m_tuser  = out_user_reg;

`ifndef SYNTH
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("singular result not zero");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
`endif
endmodule
